// ===== hw/rtl/pil_pkg.sv =====
// shared types and constants for the positional integer list
`default_nettype none

package pil_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int VAL_W = 32;
  localparam int POS_W = 8;
  localparam int CNT_OUT_W = 5;

  typedef enum logic [2:0] {
    CMD_INSERT       = 3'd0,
    CMD_REMOVE_AT    = 3'd1,
    CMD_READ         = 3'd2,
    CMD_CONTAINS     = 3'd3,
    CMD_REMOVE_VALUE = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY
  } state_t;

  // control broadcast to every cell of the chain
  typedef struct packed {
    logic              ins;
    logic              del_pos;
    logic              del_hit;
    logic              load;
    logic              scan;
    logic [POS_W-1:0]  pos;
    logic [VAL_W-1:0]  val;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pil_cell.sv =====
// one list cell: holds an entry and a match flag, shifts with its neighbors
`default_nettype none

module pil_cell
  import pil_pkg::*;
#(
  parameter int IDX  = 0,
  parameter int CNTW = 5
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire cell_ctrl_t       ctrl,
  input  wire logic [CNTW-1:0]  cnt,
  input  wire logic [VAL_W-1:0] left_entry,
  input  wire logic [VAL_W-1:0] right_entry,
  input  wire logic             left_hit,
  output logic      [VAL_W-1:0] entry,
  output logic                  hit
);

  localparam logic [8:0] SLOT = 9'(IDX);

  logic [VAL_W-1:0] entry_next;
  logic             hit_next;
  logic [8:0]       pos9;
  logic             valid;

  assign pos9  = {1'b0, ctrl.pos};
  assign valid = 9'(cnt) > SLOT;

  always_comb begin
    entry_next = entry;
    hit_next   = hit;
    if (ctrl.ins) begin
      if (SLOT + 9'd1 == pos9) begin
        entry_next = ctrl.val;
      end else if (SLOT >= pos9) begin
        entry_next = left_entry;
      end
    end
    if (ctrl.del_pos && (SLOT + 9'd1 >= pos9)) begin
      entry_next = right_entry;
    end
    // hit is the inclusive prefix of matches once the scan has settled
    if (ctrl.del_hit && hit) begin
      entry_next = right_entry;
    end
    if (ctrl.load) begin
      hit_next = valid && (entry == ctrl.val);
    end
    if (ctrl.scan) begin
      hit_next = hit | left_hit;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else begin
      hit <= hit_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/positional_int_list.sv =====
// insert, remove at position, read: result next cycle, one beat per cycle while idle
// contains, remove by value: load the flags, run ST_SCAN, result from ST_APPLY;
//   the match flag ripples one cell per cycle down the chain before the result is known
// busy is high while a by-value search runs; the receiver cannot stall results
// synchronous reset empties the list and clears all match flags and the strobe
// entry contents are not cleared at reset
`default_nettype none

module positional_int_list
  import pil_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [2:0]           command,
  input  wire logic [POS_W-1:0]     position,
  input  wire logic signed [VAL_W-1:0] item_value,
  output logic                      done,
  output logic                      ok,
  output logic signed [VAL_W-1:0]   read_value,
  output logic [CNT_OUT_W-1:0]      count
);

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CNTW = (CW > CNT_OUT_W) ? CW : CNT_OUT_W;
  localparam int SW   = (DEPTH > 2) ? $clog2(DEPTH - 1) : 1;

  state_t           state, state_next;
  logic [CNTW-1:0]  cnt, cnt_next;
  logic [SW-1:0]    scnt, scnt_next;
  logic             rm_op, rm_op_next;
  logic             done_next, ok_next;
  logic [VAL_W-1:0] rd_next;
  cell_ctrl_t       ctrl;

  logic [VAL_W-1:0] ent [DEPTH];
  logic             hit [DEPTH];

  logic             accept;
  cmd_t             cmd;
  logic [8:0]       pos9, cnt9;
  logic [VAL_W-1:0] rd_sel;

  assign busy   = state != ST_IDLE;
  assign accept = start && !busy;
  assign cmd    = cmd_t'(command);
  assign pos9   = {1'b0, position};
  assign cnt9   = 9'(cnt);
  assign count  = cnt[CNT_OUT_W-1:0];

  always_comb begin
    rd_sel = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (pos9 == 9'(i + 1)) begin
        rd_sel = ent[i];
      end
    end
  end

  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    scnt_next   = scnt;
    rm_op_next  = rm_op;
    done_next   = 1'b0;
    ok_next     = 1'b0;
    rd_next     = '0;
    ctrl        = '0;
    ctrl.pos    = position;
    ctrl.val    = item_value;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (cmd)
            CMD_INSERT: begin
              done_next = 1'b1;
              if (pos9 != 9'd0 && pos9 <= cnt9 + 9'd1 && cnt9 < 9'(DEPTH)) begin
                ctrl.ins = 1'b1;
                ok_next  = 1'b1;
                cnt_next = cnt + CNTW'(1);
              end
            end
            CMD_REMOVE_AT: begin
              done_next = 1'b1;
              if (pos9 != 9'd0 && pos9 <= cnt9) begin
                ctrl.del_pos = 1'b1;
                ok_next      = 1'b1;
                cnt_next     = cnt - CNTW'(1);
              end
            end
            CMD_READ: begin
              done_next = 1'b1;
              if (pos9 != 9'd0 && pos9 <= cnt9) begin
                ok_next = 1'b1;
                rd_next = rd_sel;
              end
            end
            CMD_CONTAINS, CMD_REMOVE_VALUE: begin
              ctrl.load  = 1'b1;
              rm_op_next = cmd == CMD_REMOVE_VALUE;
              scnt_next  = '0;
              state_next = (DEPTH > 1) ? ST_SCAN : ST_APPLY;
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        ctrl.scan = 1'b1;
        scnt_next = scnt + SW'(1);
        if (scnt == SW'(DEPTH - 2)) begin
          state_next = ST_APPLY;
        end
      end
      ST_APPLY: begin
        done_next  = 1'b1;
        ok_next    = hit[DEPTH-1];
        state_next = ST_IDLE;
        if (rm_op && hit[DEPTH-1]) begin
          ctrl.del_hit = 1'b1;
          cnt_next     = cnt - CNTW'(1);
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      scnt  <= '0;
      rm_op <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      scnt  <= scnt_next;
      rm_op <= rm_op_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    ok         <= ok_next;
    read_value <= rd_next;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VAL_W-1:0] le, re;
    logic             lh;
    if (i == 0) begin : g_first
      assign le = ent[i];
      assign lh = 1'b0;
    end else begin : g_mid
      assign le = ent[i-1];
      assign lh = hit[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign re = ent[i];
    end else begin : g_body
      assign re = ent[i+1];
    end
    pil_cell #(
      .IDX  (i),
      .CNTW (CNTW)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .cnt         (cnt),
      .left_entry  (le),
      .right_entry (re),
      .left_hit    (lh),
      .entry       (ent[i]),
      .hit         (hit[i])
    );
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    9'(cnt) <= 9'(DEPTH))
    else $error("entry count above depth");

  a_cnt_step: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> (cnt == $past(cnt) || cnt == $past(cnt) + CNTW'(1) ||
                     cnt + CNTW'(1) == $past(cnt)))
    else $error("entry count moved by more than one");

  a_apply_done: assert property (@(posedge clk) disable iff (rst)
    state == ST_APPLY |=> done)
    else $error("search finished without a result beat");

  a_search_quiet: assert property (@(posedge clk) disable iff (rst)
    (accept && (cmd == CMD_CONTAINS || cmd == CMD_REMOVE_VALUE)) |=> (!done && busy))
    else $error("result beat before search completed");

endmodule

`default_nettype wire
